@@ rtl/acfp_pkg.sv @@
// ============================================================================
// acfp_pkg
// Shared types, character codes and helpers for the command frame parser.
// ============================================================================
package acfp_pkg;

  // Line buffer sizing.
  localparam int LINE_CAPACITY = 32;
  localparam int LINE_CNT_W    = $clog2(LINE_CAPACITY);

  // Frame layout: '!', four ID characters, lock, reset scope, reader op,
  // reader digit and two checksum digits.
  localparam int FRAME_LEN   = 11;
  localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
  localparam int SUM_LEN     = 9;

  // Candidate queue between the front and the back.
  localparam int CAND_DEPTH = 2;
  localparam int CAND_PTR_W = (CAND_DEPTH > 1) ? $clog2(CAND_DEPTH) : 1;
  localparam int CAND_CNT_W = $clog2(CAND_DEPTH + 1);

  // Result queue at the output of the back.
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] ASC_LF   = 8'h0A;
  localparam logic [7:0] ASC_CR   = 8'h0D;
  localparam logic [7:0] ASC_BANG = 8'h21;
  localparam logic [7:0] ASC_0    = 8'h30;
  localparam logic [7:0] ASC_9    = 8'h39;
  localparam logic [7:0] ASC_A_UP = 8'h41;
  localparam logic [7:0] ASC_F_UP = 8'h46;
  localparam logic [7:0] ASC_A_LO = 8'h61;
  localparam logic [7:0] ASC_F_LO = 8'h66;
  localparam logic [7:0] ASC_O    = 8'h4F;
  localparam logic [7:0] ASC_C    = 8'h43;
  localparam logic [7:0] ASC_R    = 8'h52;

  // Broadcast ID, "FFFF".
  localparam logic [31:0] BCAST_ID = 32'h4646_4646;

  // A complete, well-shaped line handed from the front to the back.
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  lock;
    logic [7:0]  op;
    logic [7:0]  digit;
    logic [7:0]  ck_hi;
    logic [7:0]  ck_lo;
    logic [7:0]  sum;
  } cand_t;

  // One result item.
  typedef struct packed {
    logic       for_me;
    logic       lock_valid;
    logic       lock_open;
    logic       report_request;
    logic       scan_all;
    logic [3:0] reader_index;
  } result_t;

  // Decoded hex digit with a flag for a legal character.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= ASC_0 && c <= ASC_9) begin
      h.val = 4'(c - ASC_0);
    end else if (c >= ASC_A_UP && c <= ASC_F_UP) begin
      h.val = 4'(c - ASC_A_UP + 8'd10);
    end else if (c >= ASC_A_LO && c <= ASC_F_LO) begin
      h.val = 4'(c - ASC_A_LO + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ rtl/acfp_front.sv @@
// ============================================================================
// acfp_front
// Line collector: counts characters, keeps the frame positions and a running
// XOR, and on a terminator hands well-shaped lines to the candidate queue.
// ============================================================================
module acfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                full,
  output logic                cand_push,
  output acfp_pkg::cand_t     cand
);
  import acfp_pkg::*;

  logic [LINE_CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [7:0]            frame_r [FRAME_LEN];
  logic [7:0]            sum_r;
  logic                  accept;
  logic                  is_term;
  logic                  has_room;
  logic [FRAME_IDX_W-1:0] wr_idx;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign is_term  = (in_rx_byte == ASC_LF) || (in_rx_byte == ASC_CR);
  assign has_room = line_cnt_r < LINE_CNT_W'(LINE_CAPACITY - 1);
  assign wr_idx   = line_cnt_r[FRAME_IDX_W-1:0];

  // Next line count and the candidate push on a terminator.
  always_comb begin
    line_cnt_nxt = line_cnt_r;
    cand_push    = 1'b0;
    if (accept) begin
      if (!is_term) begin
        line_cnt_nxt = has_room ? line_cnt_r + 1'b1 : '0;
      end else begin
        line_cnt_nxt = '0;
        cand_push    = (line_cnt_r == LINE_CNT_W'(FRAME_LEN)) &&
                       (frame_r[0] == ASC_BANG);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
    end else begin
      line_cnt_r <= line_cnt_nxt;
    end
  end

  // Frame characters and the running checksum over the first positions.
  always_ff @(posedge clk) begin
    if (accept && !is_term && has_room) begin
      if (line_cnt_r < LINE_CNT_W'(FRAME_LEN)) begin
        frame_r[wr_idx] <= in_rx_byte;
      end
      if (line_cnt_r < LINE_CNT_W'(SUM_LEN)) begin
        sum_r <= (line_cnt_r == '0) ? in_rx_byte : (sum_r ^ in_rx_byte);
      end
    end
  end

  // Fields of the candidate frame.
  always_comb begin
    cand.id    = {frame_r[1], frame_r[2], frame_r[3], frame_r[4]};
    cand.lock  = frame_r[5];
    cand.op    = frame_r[7];
    cand.digit = frame_r[8];
    cand.ck_hi = frame_r[9];
    cand.ck_lo = frame_r[10];
    cand.sum   = sum_r;
  end

endmodule

@@ rtl/acfp_cand_q.sv @@
// ============================================================================
// acfp_cand_q
// Short queue of candidate frames between the front and the back.
// ============================================================================
module acfp_cand_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  acfp_pkg::cand_t wr_data,
  input  logic            rd_en,
  output logic            rd_valid,
  output acfp_pkg::cand_t rd_data,
  output logic            q_full
);
  import acfp_pkg::*;

  cand_t                 ent_r [CAND_DEPTH];
  logic [CAND_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CAND_CNT_W-1:0] cnt_r;
  logic                  do_wr, do_rd;

  assign rd_valid = (cnt_r != '0);
  assign q_full   = (cnt_r == CAND_CNT_W'(CAND_DEPTH));
  assign rd_data  = ent_r[rd_ptr_r];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == CAND_PTR_W'(CAND_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == CAND_PTR_W'(CAND_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/acfp_back.sv @@
// ============================================================================
// acfp_back
// Frame checker and decoder: address and checksum checks, command decode,
// and the result queue seen on the output side.
// ============================================================================
module acfp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cand_valid,
  input  acfp_pkg::cand_t   cand,
  input  logic [31:0]       gw_id,
  output logic              cand_pop,
  input  logic              pop,
  output logic              empty,
  output acfp_pkg::result_t res
);
  import acfp_pkg::*;

  result_t              ent_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic                 out_full;
  logic                 do_wr, do_rd;
  logic                 mine, bcast, sum_ok, good;
  logic                 is_digit;
  hex_t                 hex_hi, hex_lo;
  result_t              dec;

  assign out_full = (cnt_r == OUT_CNT_W'(OUT_DEPTH));
  assign empty    = (cnt_r == '0);
  assign res      = ent_r[rd_ptr_r];
  assign cand_pop = cand_valid && !out_full;

  // Address and checksum checks on the head candidate.
  always_comb begin
    mine     = (cand.id == gw_id);
    bcast    = (cand.id == BCAST_ID);
    hex_hi   = hex_decode(cand.ck_hi);
    hex_lo   = hex_decode(cand.ck_lo);
    sum_ok   = hex_hi.ok && hex_lo.ok && (cand.sum == {hex_hi.val, hex_lo.val});
    good     = (mine || bcast) && sum_ok;
    is_digit = (cand.digit >= ASC_0) && (cand.digit <= ASC_9);
  end

  // Command decode.
  always_comb begin
    dec.for_me         = mine;
    dec.lock_valid     = (cand.lock == ASC_O) || (cand.lock == ASC_C);
    dec.lock_open      = (cand.lock == ASC_O);
    dec.report_request = (cand.op == ASC_R) && mine;
    dec.scan_all       = dec.report_request && !is_digit;
    dec.reader_index   = (dec.report_request && is_digit) ?
                         4'(cand.digit - ASC_0) : 4'd0;
  end

  assign do_wr = cand_pop && good;
  assign do_rd = pop && !empty;

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ rtl/addressed_command_frame_parser_unit.sv @@
// ============================================================================
// addressed_command_frame_parser_unit
// Parses addressed command frames from a received character stream.
// ============================================================================
// Usage:
//   Input side is a queue: present a character on in_rx_byte with push; the
//   transfer takes place at an edge where push is high and full is low. LF or
//   CR ends a line. One character is taken every cycle while full is low.
//   Output side is a queue: while empty is low the oldest result is on the
//   out_ ports; pop takes it. A line gives a result only when it is a valid
//   eleven-character frame, addressed here or broadcast, with good checksum.
//   A frame enters the candidate queue at the terminator's transfer; the
//   back part takes it from there once the result queue has room and
//   writes it straight into the result queue, where it becomes visible.
//   The line collector takes one character per cycle while full is low;
//   frame checks are combinational and run as a frame leaves the queue.
//   When the receiver stalls, the result queue fills, then the candidate
//   queue; full rises only when the candidate queue holds two frames.
//   Reset (rst_n low, synchronous) empties both queues, clears the line
//   count and sets the gateway ID to zero. cfg_we writes cfg_data into the
//   gateway ID; write it only while the block is idle.
// ============================================================================
module addressed_command_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_for_me,
  output logic        out_lock_valid,
  output logic        out_lock_open,
  output logic        out_report_request,
  output logic        out_scan_all,
  output logic [3:0]  out_reader_index
);
  import acfp_pkg::*;

  logic [31:0] gw_id_q_r;
  logic        cand_push, cand_valid, cand_pop, q_full;
  cand_t       cand_in, cand_out;
  result_t     res;

  // Gateway ID register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_id_q_r <= '0;
    end else begin
      if (cfg_we) begin
        gw_id_q_r <= cfg_data;
      end
    end
  end

  // Front: line collection and shape check.
  acfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .full       (full),
    .cand_push  (cand_push),
    .cand       (cand_in)
  );

  // Candidate queue between front and back.
  acfp_cand_q u_cand_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cand_push),
    .wr_data  (cand_in),
    .rd_en    (cand_pop),
    .rd_valid (cand_valid),
    .rd_data  (cand_out),
    .q_full   (q_full)
  );

  // Back: frame checks, decode and result queue.
  acfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (cand_valid),
    .cand       (cand_out),
    .gw_id      (gw_id_q_r),
    .cand_pop   (cand_pop),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  // Result fields onto the ports.
  assign out_for_me         = res.for_me;
  assign out_lock_valid     = res.lock_valid;
  assign out_lock_open      = res.lock_open;
  assign out_report_request = res.report_request;
  assign out_scan_all       = res.scan_all;
  assign out_reader_index   = res.reader_index;

endmodule

@@ rtl/acfp_checker.sv @@
// ============================================================================
// acfp_checker
// Port-level checks on the command frame parser, bound to the top level.
// ============================================================================
module acfp_checker (
  input logic clk,
  input logic rst_n,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop
);

  // Reset leaves the result queue empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Reset leaves the input side able to take a transfer.
  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  // The input side can only fill up through an accepted transfer.
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!full && !push) |=> !full)
    else $error("full rose without an input transfer");

  // A waiting result is never lost without a pop.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result vanished without a pop");

endmodule

bind addressed_command_frame_parser_unit acfp_checker u_acfp_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .push  (push),
  .full  (full),
  .empty (empty),
  .pop   (pop)
);

@@ sim/acfp_frame_monitor.sv @@
// ----------------------------------------------------------------------------
// acfp_frame_monitor
// Watches the character, result and gateway ID ports of the command frame
// parser. It keeps its own line collector and frame checks, queues the
// command expected from every line that passes them, and compares each result
// transfer with the oldest queued command, field by field.
// ----------------------------------------------------------------------------
module acfp_frame_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_for_me,
  input  logic        out_lock_valid,
  input  logic        out_lock_open,
  input  logic        out_report_request,
  input  logic        out_scan_all,
  input  logic [3:0]  out_reader_index,
  output int          mismatch_count,
  output int          commands_waiting
);
  import acfp_pkg::*;

  // Mirror of the parser state: gateway ID, line length and kept characters.
  logic [31:0] gw_id;
  int          line_len;
  logic [7:0]  line_chars [FRAME_LEN];
  result_t     pending_commands [$];

  initial begin
    mismatch_count   = 0;
    commands_waiting = 0;
    gw_id            = '0;
    line_len         = 0;
  end

  // Value of a checksum character, or -1 when it is not a hex digit.
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= ASC_0 && c <= ASC_9) return int'(c) - int'(ASC_0);
    if (c >= ASC_A_UP && c <= ASC_F_UP) return int'(c) - int'(ASC_A_UP) + 10;
    if (c >= ASC_A_LO && c <= ASC_F_LO) return int'(c) - int'(ASC_A_LO) + 10;
    return -1;
  endfunction

  // Takes one accepted character; a terminator may queue one command.
  task automatic absorb_link_char(input logic [7:0] c);
    logic [31:0] frame_id;
    logic [7:0]  sum;
    logic [7:0]  digit;
    logic        mine;
    logic        bcast;
    int          hi;
    int          lo;
    result_t     cmd;
    if (c != ASC_LF && c != ASC_CR) begin
      // Characters past the frame length are counted but not kept; a full
      // buffer throws the whole line away together with this character.
      if (line_len < LINE_CAPACITY - 1) begin
        if (line_len < FRAME_LEN) line_chars[line_len] = c;
        line_len++;
      end else begin
        line_len = 0;
      end
    end else begin
      if (line_len == FRAME_LEN && line_chars[0] == ASC_BANG) begin
        frame_id = {line_chars[1], line_chars[2], line_chars[3], line_chars[4]};
        mine     = (frame_id == gw_id);
        bcast    = (frame_id == BCAST_ID);
        hi       = nibble_of(line_chars[9]);
        lo       = nibble_of(line_chars[10]);
        sum      = '0;
        for (int k = 0; k < SUM_LEN; k++) sum ^= line_chars[k];
        if ((mine || bcast) && hi >= 0 && lo >= 0 && sum == 8'(hi * 16 + lo)) begin
          digit              = line_chars[8];
          cmd.for_me         = mine;
          cmd.lock_valid     = (line_chars[5] == ASC_O) || (line_chars[5] == ASC_C);
          cmd.lock_open      = (line_chars[5] == ASC_O);
          cmd.report_request = mine && (line_chars[7] == ASC_R);
          cmd.scan_all       = cmd.report_request && !(digit >= ASC_0 && digit <= ASC_9);
          cmd.reader_index   = (cmd.report_request && !cmd.scan_all) ?
                               4'(digit - ASC_0) : 4'd0;
          pending_commands.push_back(cmd);
        end
      end
      line_len = 0;
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Prediction on every character transfer, comparison on every result
  // transfer.
  always @(posedge clk) begin : observe
    result_t want;
    result_t seen;
    if (!rst_n) begin
      gw_id    = '0;
      line_len = 0;
      pending_commands.delete();
    end else begin
      if (cfg_we) gw_id = cfg_data;
      if (push && !full) absorb_link_char(in_rx_byte);
      if (pop && !empty) begin
        seen = {out_for_me, out_lock_valid, out_lock_open, out_report_request,
                out_scan_all, out_reader_index};
        if (pending_commands.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, seen);
          mismatch_count++;
        end else begin
          want = pending_commands.pop_front();
          check_field("for_me", want.for_me, seen.for_me);
          check_field("lock_valid", want.lock_valid, seen.lock_valid);
          check_field("lock_open", want.lock_open, seen.lock_open);
          check_field("report_request", want.report_request, seen.report_request);
          check_field("scan_all", want.scan_all, seen.scan_all);
          check_field("reader_index", want.reader_index, seen.reader_index);
        end
      end
    end
    commands_waiting = pending_commands.size();
  end

endmodule

@@ sim/addressed_command_frame_parser_unit_tb.sv @@
// ----------------------------------------------------------------------------
// addressed_command_frame_parser_unit_tb
// Drives character lines into the command frame parser: a directed set of
// frames and malformed lines, then random frames, broken frames, noise and
// overflowing lines under several gateway IDs. Sender bursts and receiver
// stalls vary throughout; the monitor checks every result.
// ----------------------------------------------------------------------------
module addressed_command_frame_parser_unit_tb;
  import acfp_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TARGET_CHARS  = 560;
  localparam int PHASE_CHARS   = 110;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_t;
  typedef enum {FLAW_SHORT, FLAW_LONG, FLAW_START, FLAW_HEX} frame_flaw_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_data   = '0;
  logic        push       = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        pop        = 1'b0;
  logic        full;
  logic        empty;
  logic        out_for_me;
  logic        out_lock_valid;
  logic        out_lock_open;
  logic        out_report_request;
  logic        out_scan_all;
  logic [3:0]  out_reader_index;

  int          mismatch_count;
  int          commands_waiting;
  int          burst_left = 0;
  int          chars_sent = 0;
  int          idle_cycles = 0;
  logic [31:0] own_id = '0;
  logic [7:0]  line_q [$];

  rx_pattern_t rx_pattern   = RX_FREE;
  int          rx_left      = 0;
  int          rx_hold      = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  addressed_command_frame_parser_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .push               (push),
    .full               (full),
    .in_rx_byte         (in_rx_byte),
    .empty              (empty),
    .pop                (pop),
    .out_for_me         (out_for_me),
    .out_lock_valid     (out_lock_valid),
    .out_lock_open      (out_lock_open),
    .out_report_request (out_report_request),
    .out_scan_all       (out_scan_all),
    .out_reader_index   (out_reader_index)
  );

  acfp_frame_monitor u_mon (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .push               (push),
    .full               (full),
    .in_rx_byte         (in_rx_byte),
    .empty              (empty),
    .pop                (pop),
    .out_for_me         (out_for_me),
    .out_lock_valid     (out_lock_valid),
    .out_lock_open      (out_lock_open),
    .out_report_request (out_report_request),
    .out_scan_all       (out_scan_all),
    .out_reader_index   (out_reader_index),
    .mismatch_count     (mismatch_count),
    .commands_waiting   (commands_waiting)
  );

  // Receiver: switches at random between free running, coin toss, sparse
  // and bursty stall patterns.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        rx_left    = $urandom_range(20, 150);
      end
      rx_left--;
      case (rx_pattern)
        RX_FREE:   pop <= 1'b1;
        RX_COIN:   pop <= 1'($urandom_range(0, 1));
        RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(5, 40);
          end
        end
      endcase
    end
  end

  // Watchdog: ends the run once nothing has been transferred for too long.
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Any character except a line terminator.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ASC_LF || c == ASC_CR);
    return c;
  endfunction

  // Hex digit character in a random letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic lower;
    lower = 1'($urandom_range(0, 1));
    if (n < 4'd10) return ASC_0 + 8'(n);
    return (lower ? ASC_A_LO : ASC_A_UP) + 8'(n - 4'd10);
  endfunction

  // One character transfer; bursts end in a random, sometimes empty, gap with push low.
  task automatic put_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200) :
                                                 $urandom_range(1, 24);
    end
    burst_left--;
    push       <= 1'b1;
    in_rx_byte <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_line(input logic [7:0] term);
    foreach (line_q[i]) put_char(line_q[i]);
    put_char(term);
    line_q.delete();
  endtask

  // Fills the line with a frame; a bad sum is the true XOR with bits flipped.
  task automatic build_frame(input logic [31:0] id, input logic [7:0] lock,
                             input logic [7:0] scope, input logic [7:0] op,
                             input logic [7:0] digit, input logic good_sum);
    logic [7:0] sum;
    line_q.delete();
    line_q.push_back(ASC_BANG);
    line_q.push_back(id[31:24]);
    line_q.push_back(id[23:16]);
    line_q.push_back(id[15:8]);
    line_q.push_back(id[7:0]);
    line_q.push_back(lock);
    line_q.push_back(scope);
    line_q.push_back(op);
    line_q.push_back(digit);
    sum = '0;
    foreach (line_q[i]) sum ^= line_q[i];
    if (!good_sum) sum ^= 8'($urandom_range(1, 255));
    line_q.push_back(hex_char(sum[7:4]));
    line_q.push_back(hex_char(sum[3:0]));
  endtask

  // Frame with random content, mostly addressed here or broadcast.
  task automatic random_frame(input logic good_sum);
    logic [31:0] id;
    logic [7:0]  lock;
    logic [7:0]  op;
    logic [7:0]  digit;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) id = own_id;
    else if (pick < 8) id = BCAST_ID;
    else if (pick == 8) id = own_id ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
    else id = {body_char(), body_char(), body_char(), body_char()};
    pick = $urandom_range(0, 9);
    lock = (pick < 4) ? ASC_O : (pick < 8) ? ASC_C : body_char();
    op    = ($urandom_range(0, 9) < 6) ? ASC_R : body_char();
    digit = ($urandom_range(0, 9) < 7) ? ASC_0 + 8'($urandom_range(0, 9)) : body_char();
    build_frame(id, lock, body_char(), op, digit, good_sum);
  endtask

  // Waits with the sender paused until every expected result has come, then
  // lets the block settle.
  task automatic drain_results();
    push <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (commands_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_gateway(input logic [31:0] id);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= id;
    @(posedge clk);
    cfg_we   <= 1'b0;
    own_id = id;
  endtask

  function automatic logic [31:0] pick_gateway(input int phase_no);
    case (phase_no % 5)
      0: return {body_char(), body_char(), body_char(), body_char()};
      1: return 32'h0000_0000;
      2: return 32'hFFFF_FFFF;
      3: return BCAST_ID;
      default: return {8'($urandom_range(8'h21, 8'h7E)), 8'($urandom_range(8'h21, 8'h7E)),
                       8'($urandom_range(8'h21, 8'h7E)), 8'($urandom_range(8'h21, 8'h7E))};
    endcase
  endfunction

  // Stimulus and verdict.
  initial begin
    int          start_count;
    int          phase_start;
    int          phase_no;
    int          pick;
    frame_flaw_t flaw;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Gateway ID is zero after reset, so an all-zero ID addresses this unit.
    build_frame(32'h0, ASC_O, 8'h00, ASC_R, ASC_0 + 8'd5, 1'b1);
    send_line(ASC_LF);
    // An empty line does nothing.
    send_line(ASC_CR);

    set_gateway(32'h4757_3031);
    build_frame(own_id, ASC_C, 8'hFF, ASC_R, ASC_9, 1'b1);
    send_line(ASC_CR);
    build_frame(own_id, 8'h00, 8'h41, ASC_R, 8'h2A, 1'b1);
    send_line(ASC_LF);
    build_frame(own_id, ASC_O, 8'h7F, ASC_R, ASC_0, 1'b1);
    send_line(ASC_LF);
    // A broadcast report request is dropped, the lock command is kept.
    build_frame(BCAST_ID, ASC_O, 8'h80, ASC_R, ASC_0, 1'b1);
    send_line(ASC_LF);
    build_frame(own_id, ASC_O, 8'h01, 8'hFF, ASC_0, 1'b0);
    send_line(ASC_LF);
    // Checksum character that is not a hex digit.
    build_frame(own_id, ASC_C, 8'h01, ASC_R, ASC_0, 1'b1);
    line_q[9] = 8'h47;
    send_line(ASC_CR);
    // Wrong length, both shorter and longer, and a wrong first character.
    build_frame(own_id, ASC_C, 8'h01, ASC_R, ASC_0, 1'b1);
    void'(line_q.pop_back());
    send_line(ASC_LF);
    build_frame(own_id, ASC_C, 8'h01, ASC_R, ASC_0, 1'b1);
    repeat (6) line_q.push_back(body_char());
    send_line(ASC_LF);
    build_frame(own_id, ASC_C, 8'h01, ASC_R, ASC_0, 1'b1);
    line_q[0] = 8'h3F;
    send_line(ASC_LF);
    // Overflow: the discarded line leaves a clean start for the next frame.
    repeat (32) put_char(body_char());
    build_frame(BCAST_ID, ASC_C, 8'h01, ASC_R, ASC_0, 1'b1);
    send_line(ASC_LF);
    repeat (31) put_char(body_char());
    send_line(ASC_CR);
    // Own ID equal to the broadcast ID counts as addressed here.
    set_gateway(BCAST_ID);
    build_frame(BCAST_ID, ASC_O, 8'h00, ASC_R, 8'hFF, 1'b1);
    send_line(ASC_LF);
    set_gateway(32'hFFFF_FFFF);
    build_frame(32'hFFFF_FFFF, ASC_C, 8'hFF, ASC_R, ASC_9, 1'b1);
    send_line(ASC_CR);

    // Random part: mostly well-formed frames, some broken ones, noise and
    // overflowing lines, with the gateway ID changed between phases.
    start_count = chars_sent;
    phase_start = chars_sent;
    phase_no    = 0;
    while (chars_sent - start_count < TARGET_CHARS) begin
      if (chars_sent - phase_start >= PHASE_CHARS) begin
        set_gateway(pick_gateway(phase_no));
        phase_no++;
        phase_start = chars_sent;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        random_frame($urandom_range(0, 7) != 0);
      end else if (pick < 80) begin
        random_frame(1'b1);
        flaw = frame_flaw_t'($urandom_range(0, 3));
        case (flaw)
          FLAW_SHORT: void'(line_q.pop_back());
          FLAW_LONG:  line_q.push_back(body_char());
          FLAW_START: line_q[0] = body_char();
          default:    line_q[9 + $urandom_range(0, 1)] = 8'h47 + 8'($urandom_range(0, 19));
        endcase
      end else if (pick < 93) begin
        repeat ($urandom_range(0, 16)) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(31, 40)) put_char(body_char());
        random_frame(1'b1);
      end
      send_line($urandom_range(0, 1) ? ASC_LF : ASC_CR);
    end

    drain_results();
    if (mismatch_count == 0 && commands_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/acfp_pkg.sv
rtl/acfp_front.sv
rtl/acfp_cand_q.sv
rtl/acfp_back.sv
rtl/addressed_command_frame_parser_unit.sv
rtl/acfp_checker.sv
sim/acfp_frame_monitor.sv
sim/addressed_command_frame_parser_unit_tb.sv
